/* design/ttkp_pkg.sv */
// Shared definitions for the temporal text key parser: key ranks, grammar
// characters, the snapshot record passed to the key stage and the fraction scale.
// No dependencies.
`default_nettype none

package ttkp_pkg;

  typedef enum logic [1:0] {
    RANK_UNPARSED  = 2'd0,
    RANK_ZERO_DATE = 2'd1,
    RANK_PARSED    = 2'd2
  } key_rank_e;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [3:0]  PREFIX_LEN  = 4'd10;
  localparam logic [3:0]  PREFIX_FAIL = 4'd15;
  localparam logic [13:0] LEAD_MAX    = 14'd16383;
  localparam logic [3:0]  HEAD_MAX    = 4'd10;

  // Everything the key stage needs from the parser, apart from the fraction.
  typedef struct packed {
    key_rank_e   rank;
    logic        is_date;
    logic        negate;
    logic [13:0] lead;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } key_fields_t;

  // Character expected at each position of the zero-date text 0000-00-00.
  function automatic logic [7:0] zero_date_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd4, 4'd7: ch = CH_DASH;
      default:    ch = CH_ZERO;
    endcase
    return ch;
  endfunction

  // Factor that turns a fraction of the given digit count into nanoseconds.
  function automatic logic [26:0] ns_scale(input logic [3:0] digits);
    logic [26:0] s;
    case (digits)
      4'd1:    s = 27'd100000000;
      4'd2:    s = 27'd10000000;
      4'd3:    s = 27'd1000000;
      4'd4:    s = 27'd100000;
      4'd5:    s = 27'd10000;
      4'd6:    s = 27'd1000;
      4'd7:    s = 27'd100;
      4'd8:    s = 27'd10;
      4'd9:    s = 27'd1;
      default: s = 27'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/temporal_text_key_parser_top.sv */
// Temporal text key parser: character-serial grammar check and key build.
// Depends on ttkp_pkg.
`default_nettype none

// The block takes at most one character of a date, date-time or signed time text
// per transaction and, on the transaction that ends the text, produces one sort
// key (rank, yyyymmdd date code, seconds, nanoseconds). It accepts one character
// in every cycle unless the input is held off: the parser state is updated on each
// accepted transaction, the final state is caught in a snapshot register at the
// edge that accepts the end-of-text transaction and the key stage (constant
// multiplies and one fraction-scale multiplier) fills the output register from
// the snapshot when the output is free to advance. A new text may start right
// after the previous one ends; while the output is stalled and the snapshot
// register is full, the input is held off for every transaction.
module temporal_text_key_parser_top import ttkp_pkg::*; #(
  parameter int unsigned MAX_FRACTION_DIGITS = 9
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [7:0]         text_char_i,
  input  wire                has_char_i,
  input  wire                end_of_text_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [1:0]         key_rank_o,
  output logic [26:0]        date_code_o,
  output logic signed [22:0] seconds_o,
  output logic signed [30:0] nanoseconds_o
);

  localparam int unsigned FracW = $clog2(10 ** MAX_FRACTION_DIGITS);
  localparam int unsigned FdW   = $clog2(MAX_FRACTION_DIGITS + 1);

  localparam logic [4:0] PH_START       = 5'd0;
  localparam logic [4:0] PH_HEAD        = 5'd1;
  localparam logic [4:0] PH_MON0        = 5'd2;
  localparam logic [4:0] PH_MON1        = 5'd3;
  localparam logic [4:0] PH_DASH        = 5'd4;
  localparam logic [4:0] PH_DAY0        = 5'd5;
  localparam logic [4:0] PH_DAY1        = 5'd6;
  localparam logic [4:0] PH_AFTER_DATE  = 5'd7;
  localparam logic [4:0] PH_HOUR0       = 5'd8;
  localparam logic [4:0] PH_HOUR1       = 5'd9;
  localparam logic [4:0] PH_COLON_HM    = 5'd10;
  localparam logic [4:0] PH_MIN0        = 5'd11;
  localparam logic [4:0] PH_MIN1        = 5'd12;
  localparam logic [4:0] PH_COLON_MS    = 5'd13;
  localparam logic [4:0] PH_SEC0        = 5'd14;
  localparam logic [4:0] PH_SEC1        = 5'd15;
  localparam logic [4:0] PH_AFTER_SEC   = 5'd16;
  localparam logic [4:0] PH_FRAC        = 5'd17;
  localparam logic [4:0] PH_TZ_END      = 5'd18;
  localparam logic [4:0] PH_OFF_H0      = 5'd19;
  localparam logic [4:0] PH_OFF_H1      = 5'd20;
  localparam logic [4:0] PH_OFF_AFTER_H = 5'd21;
  localparam logic [4:0] PH_OFF_M0      = 5'd22;
  localparam logic [4:0] PH_OFF_M1      = 5'd23;

  function automatic logic [6:0] acc_dec7(input logic [6:0] v, input logic [3:0] d);
    logic [10:0] t;
    t = {4'd0, v} * 11'd10 + {7'd0, d};
    return t[6:0];
  endfunction

  // Parser state.
  logic [4:0]       phase_q, phase_d;
  logic [3:0]       dcount_q, dcount_d;
  logic [13:0]      lead_q, lead_d;
  logic             neg_q, neg_d;
  logic [6:0]       month_q, month_d;
  logic [6:0]       day_q, day_d;
  logic [6:0]       hour_q, hour_d;
  logic [6:0]       minute_q, minute_d;
  logic [6:0]       second_q, second_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [FdW-1:0]   fdig_q, fdig_d;
  logic [3:0]       zmatch_q, zmatch_d;
  logic             offnz_q, offnz_d;
  logic             rej_q, rej_d;

  // Snapshot and output stages.
  logic             snap_valid_q;
  key_fields_t      snap_q, snap_d;
  logic [FracW-1:0] snap_frac_q;
  logic [FdW-1:0]   snap_fdig_q;
  logic             out_valid_q;

  logic             accept, out_adv, snap_free;
  logic [7:0]       ch;
  logic             dig;
  logic [3:0]       dval;
  logic [17:0]      lead_mul;
  logic [FracW+3:0] frac_mul;
  logic             ok;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign snap_free  = !snap_valid_q || out_adv;
  assign in_ready_o = snap_free;
  assign accept     = in_valid_i && in_ready_o;

  assign ch       = text_char_i;
  assign dig      = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval     = dig ? ch[3:0] : 4'd0;
  assign lead_mul = {4'd0, lead_q} * 18'd10 + {14'd0, dval};
  assign frac_mul = {4'd0, frac_q} * (FracW+4)'(10) + (FracW+4)'(dval);

  always_comb begin
    phase_d  = phase_q;
    dcount_d = dcount_q;
    lead_d   = lead_q;
    neg_d    = neg_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    frac_d   = frac_q;
    fdig_d   = fdig_q;
    zmatch_d = zmatch_q;
    offnz_d  = offnz_q;
    rej_d    = rej_q;

    if (has_char_i) begin
      if (zmatch_q < PREFIX_LEN) begin
        zmatch_d = (ch == zero_date_char(zmatch_q)) ? zmatch_q + 4'd1 : PREFIX_FAIL;
      end
      // A rejected text only keeps feeding the zero-date prefix test.
      if (!rej_q) begin
        unique case (phase_q)
          PH_START: begin
            if (ch == CH_DASH) begin
              neg_d   = 1'b1;
              phase_d = PH_HEAD;
            end else if (dig) begin
              dcount_d = 4'd1;
              lead_d   = {10'd0, dval};
              phase_d  = PH_HEAD;
            end else begin
              rej_d = 1'b1;
            end
          end
          PH_HEAD: begin
            if (dig) begin
              if (dcount_q >= HEAD_MAX) begin
                rej_d = 1'b1;
              end else begin
                dcount_d = dcount_q + 4'd1;
                lead_d   = (lead_mul > {4'd0, LEAD_MAX}) ? LEAD_MAX : lead_mul[13:0];
              end
            end else if (ch == CH_DASH && !neg_q && dcount_q == 4'd4) begin
              phase_d = PH_MON0;
            end else if (ch == CH_COLON && dcount_q >= 4'd1 && dcount_q <= 4'd3) begin
              phase_d = PH_MIN0;
            end else begin
              rej_d = 1'b1;
            end
          end
          PH_MON0, PH_MON1: begin
            if (!dig) begin
              rej_d = 1'b1;
            end else begin
              month_d = acc_dec7(month_q, dval);
              phase_d = (phase_q == PH_MON0) ? PH_MON1 : PH_DASH;
            end
          end
          PH_DASH: begin
            if (ch == CH_DASH) phase_d = PH_DAY0;
            else rej_d = 1'b1;
          end
          PH_DAY0, PH_DAY1: begin
            if (!dig) begin
              rej_d = 1'b1;
            end else begin
              day_d = acc_dec7(day_q, dval);
              if (phase_q == PH_DAY0) begin
                phase_d = PH_DAY1;
              end else begin
                if (month_q < 7'd1 || month_q > 7'd12 || day_d < 7'd1 || day_d > 7'd31) begin
                  rej_d = 1'b1;
                end
                phase_d = PH_AFTER_DATE;
              end
            end
          end
          PH_AFTER_DATE: begin
            if (ch == CH_SPACE || ch == CH_UP_T || ch == CH_LO_T) phase_d = PH_HOUR0;
            else rej_d = 1'b1;
          end
          PH_HOUR0, PH_HOUR1: begin
            if (!dig) begin
              rej_d = 1'b1;
            end else begin
              hour_d  = acc_dec7(hour_q, dval);
              phase_d = (phase_q == PH_HOUR0) ? PH_HOUR1 : PH_COLON_HM;
            end
          end
          PH_COLON_HM: begin
            if (ch == CH_COLON) phase_d = PH_MIN0;
            else rej_d = 1'b1;
          end
          PH_MIN0, PH_MIN1: begin
            if (!dig) begin
              rej_d = 1'b1;
            end else begin
              minute_d = acc_dec7(minute_q, dval);
              phase_d  = (phase_q == PH_MIN0) ? PH_MIN1 : PH_COLON_MS;
            end
          end
          PH_COLON_MS: begin
            if (ch == CH_COLON) phase_d = PH_SEC0;
            else rej_d = 1'b1;
          end
          PH_SEC0, PH_SEC1: begin
            if (!dig) begin
              rej_d = 1'b1;
            end else begin
              second_d = acc_dec7(second_q, dval);
              if (phase_q == PH_SEC0) begin
                phase_d = PH_SEC1;
              end else begin
                // A date-time limits the hour; a bare time limits the hour count.
                if (month_q != 7'd0) begin
                  if (hour_q > 7'd23) rej_d = 1'b1;
                end else if (lead_q > 14'd838) begin
                  rej_d = 1'b1;
                end
                if (minute_q > 7'd59 || second_d > 7'd60) rej_d = 1'b1;
                phase_d = PH_AFTER_SEC;
              end
            end
          end
          PH_AFTER_SEC: begin
            if (ch == CH_DOT) phase_d = PH_FRAC;
            else if (ch == CH_UP_Z || ch == CH_LO_Z) phase_d = PH_TZ_END;
            else if (ch == CH_PLUS || ch == CH_DASH) phase_d = PH_OFF_H0;
            else rej_d = 1'b1;
          end
          PH_FRAC: begin
            if (dig) begin
              if (fdig_q >= FdW'(MAX_FRACTION_DIGITS)) begin
                rej_d = 1'b1;
              end else begin
                frac_d = frac_mul[FracW-1:0];
                fdig_d = FdW'(fdig_q + 1'b1);
              end
            end else if (fdig_q == '0) begin
              rej_d = 1'b1;
            end else if (ch == CH_UP_Z || ch == CH_LO_Z) begin
              phase_d = PH_TZ_END;
            end else if (ch == CH_PLUS || ch == CH_DASH) begin
              phase_d = PH_OFF_H0;
            end else begin
              rej_d = 1'b1;
            end
          end
          PH_OFF_H0, PH_OFF_H1, PH_OFF_M0, PH_OFF_M1: begin
            if (!dig) begin
              rej_d = 1'b1;
            end else begin
              if (dval != 4'd0) offnz_d = 1'b1;
              if (phase_q == PH_OFF_H0)      phase_d = PH_OFF_H1;
              else if (phase_q == PH_OFF_H1) phase_d = PH_OFF_AFTER_H;
              else if (phase_q == PH_OFF_M0) phase_d = PH_OFF_M1;
              else                           phase_d = PH_TZ_END;
            end
          end
          PH_OFF_AFTER_H: begin
            if (ch == CH_COLON) begin
              phase_d = PH_OFF_M0;
            end else if (dig) begin
              if (dval != 4'd0) offnz_d = 1'b1;
              phase_d = PH_OFF_M1;
            end else begin
              rej_d = 1'b1;
            end
          end
          default: rej_d = 1'b1;
        endcase
      end
    end
  end

  // Classification of the text as it stands after this transaction.
  always_comb begin
    ok = !rej_d && !offnz_d &&
         (phase_d == PH_AFTER_DATE || phase_d == PH_AFTER_SEC || phase_d == PH_TZ_END ||
          phase_d == PH_OFF_AFTER_H || (phase_d == PH_FRAC && fdig_d != '0));
    snap_d.rank    = (zmatch_d == PREFIX_LEN) ? RANK_ZERO_DATE :
                     ok ? RANK_PARSED : RANK_UNPARSED;
    snap_d.is_date = (month_d != 7'd0);
    snap_d.negate  = neg_d && (month_d == 7'd0);
    snap_d.lead    = lead_d;
    snap_d.month   = month_d;
    snap_d.day     = day_d;
    snap_d.hour    = hour_d;
    snap_d.minute  = minute_d;
    snap_d.second  = second_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      dcount_q <= '0;
      lead_q   <= '0;
      neg_q    <= 1'b0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      fdig_q   <= '0;
      zmatch_q <= '0;
      offnz_q  <= 1'b0;
      rej_q    <= 1'b0;
    end else if (accept && end_of_text_i) begin
      phase_q  <= PH_START;
      dcount_q <= '0;
      lead_q   <= '0;
      neg_q    <= 1'b0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      fdig_q   <= '0;
      zmatch_q <= '0;
      offnz_q  <= 1'b0;
      rej_q    <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      dcount_q <= dcount_d;
      lead_q   <= lead_d;
      neg_q    <= neg_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      frac_q   <= frac_d;
      fdig_q   <= fdig_d;
      zmatch_q <= zmatch_d;
      offnz_q  <= offnz_d;
      rej_q    <= rej_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (accept && end_of_text_i) begin
      snap_valid_q <= 1'b1;
    end else if (out_adv) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && end_of_text_i) begin
      snap_q      <= snap_d;
      snap_frac_q <= frac_d;
      snap_fdig_q <= fdig_d;
    end
  end

  // Key stage.
  logic [13:0]         hours_sel;
  logic [25:0]         secs_sum;
  logic [27:0]         date_sum;
  logic [FracW+26:0]   ns_prod;
  logic [22:0]         secs_mag;
  logic [30:0]         ns_mag;
  logic                parsed;
  logic [1:0]          rank_d;
  logic [26:0]         date_d;
  logic [22:0]         secs_d;
  logic [30:0]         ns_d;

  always_comb begin
    parsed    = (snap_q.rank == RANK_PARSED);
    hours_sel = snap_q.is_date ? {7'd0, snap_q.hour} : snap_q.lead;
    secs_sum  = {12'd0, hours_sel} * 26'd3600 + {19'd0, snap_q.minute} * 26'd60 +
                {19'd0, snap_q.second};
    date_sum  = {14'd0, snap_q.lead} * 28'd10000 + {21'd0, snap_q.month} * 28'd100 +
                {21'd0, snap_q.day};
    ns_prod   = {27'd0, snap_frac_q} * {{FracW{1'b0}}, ns_scale(4'(snap_fdig_q))};
    secs_mag  = secs_sum[22:0];
    ns_mag    = ns_prod[30:0];
    rank_d    = snap_q.rank;
    date_d    = '0;
    secs_d    = '0;
    ns_d      = '0;
    if (parsed) begin
      if (snap_q.is_date) date_d = date_sum[26:0];
      secs_d = snap_q.negate ? 23'd0 - secs_mag : secs_mag;
      ns_d   = snap_q.negate ? 31'd0 - ns_mag : ns_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && snap_valid_q) begin
      key_rank_o    <= rank_d;
      date_code_o   <= date_d;
      seconds_o     <= secs_d;
      nanoseconds_o <= ns_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
